/* design/uis_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the unique ID set.
package uis_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 31;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic    load;
    logic    rd_scan;
    logic    cmp;
    logic    rd_next;
    logic    wr_shift;
    logic    do_insert;
    logic    dec_count;
    logic    set_status;
    status_t status_code;
    logic    load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              found;
    logic              match;
    logic              idx_lt_count;
    logic              next_lt_count;
    logic              full;
    logic              res_free;
  } dp_stat_t;

endpackage

/* design/uis_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/uis_datapath.sv */
// Datapath: entry store, scan index, entry count, status and result register.
module uis_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [uis_pkg::MODE_W-1:0]   mode,
  input  logic [uis_pkg::ID_W-1:0]     id_value,
  input  uis_pkg::ctrl_cmd_t           cmd,
  output uis_pkg::dp_stat_t            stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [uis_pkg::STATUS_W-1:0] status,
  output logic [uis_pkg::COUNT_W-1:0]  entry_count
);
  import uis_pkg::*;

  logic [MODE_W-1:0]  mode_q;
  logic [ID_W-1:0]    id_q;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   idx_inc;
  logic [CNT_W-1:0]   count;
  logic               found;
  status_t            status_q;
  status_t            status_r;
  logic [COUNT_W-1:0] entry_count_r;

  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [ID_W-1:0]    rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ID_W-1:0]    wr_data;

  assign idx_inc = idx + CNT_W'(1);

  assign rd_en   = cmd.rd_scan | cmd.rd_next;
  assign rd_addr = cmd.rd_next ? idx_inc[IDX_W-1:0] : idx[IDX_W-1:0];
  assign wr_en   = cmd.do_insert | cmd.wr_shift;
  assign wr_addr = cmd.do_insert ? count[IDX_W-1:0] : idx[IDX_W-1:0];
  assign wr_data = cmd.do_insert ? id_q : rd_data;

  uis_ram #(
    .WIDTH (ID_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    stat.mode          = mode_q;
    stat.found         = found;
    stat.match         = (rd_data == id_q);
    stat.idx_lt_count  = (idx < count);
    stat.next_lt_count = (idx_inc < count);
    stat.full          = (count == CNT_W'(CAPACITY));
    stat.res_free      = ~out_valid | out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q <= mode;
      id_q   <= id_value;
    end
    if (cmd.set_status) begin
      status_q <= cmd.status_code;
    end
    if (cmd.load_result) begin
      status_r      <= status_q;
      entry_count_r <= COUNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.load) begin
      idx   <= '0;
      found <= 1'b0;
    end else if (cmd.cmp) begin
      if (stat.match) begin
        found <= 1'b1;
      end else begin
        idx <= idx_inc;
      end
    end else if (cmd.wr_shift) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.do_insert) begin
      count <= count + CNT_W'(1);
    end else if (cmd.dec_count) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status      = status_r;
  assign entry_count = entry_count_r;

endmodule

/* design/uis_ctrl.sv */
// Controller: sequences scan, insert, remove-with-shift and result transfer.
module uis_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output uis_pkg::ctrl_cmd_t cmd,
  input  uis_pkg::dp_stat_t  stat
);
  import uis_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = stat.idx_lt_count ? S_SCAN_CMP : S_DECIDE;
      end
      S_SCAN_CMP: begin
        state_next = stat.match ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        if (stat.mode == MODE_REMOVE && stat.found) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_RESULT;
        end
      end
      S_SHIFT_RD: begin
        state_next = stat.next_lt_count ? S_SHIFT_WR : S_RESULT;
      end
      S_SHIFT_WR: begin
        state_next = S_SHIFT_RD;
      end
      S_RESULT: begin
        if (stat.res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SCAN_RD: begin
        cmd.rd_scan = stat.idx_lt_count;
      end
      S_SCAN_CMP: begin
        cmd.cmp = 1'b1;
      end
      S_DECIDE: begin
        cmd.set_status = 1'b1;
        if (stat.mode == MODE_INSERT) begin
          if (stat.found) begin
            cmd.status_code = STATUS_MISS;
          end else if (stat.full) begin
            cmd.status_code = STATUS_FULL;
          end else begin
            cmd.status_code = STATUS_OK;
            cmd.do_insert   = 1'b1;
          end
        end else begin
          cmd.status_code = stat.found ? STATUS_OK : STATUS_MISS;
        end
      end
      S_SHIFT_RD: begin
        if (stat.next_lt_count) begin
          cmd.rd_next = 1'b1;
        end else begin
          cmd.dec_count = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
      end
      S_RESULT: begin
        cmd.load_result = stat.res_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/unique_id_set.sv */
// Top level of the unique ID set: controller plus datapath.
// Holds up to CAPACITY unique 31-bit IDs in insertion order in a single-port-read RAM.
// Each input transfer gives one result transfer (status and entry count after the
// operation). The membership scan visits the held entries in order, each with one
// RAM read plus one compare, and stops at a match; on a miss it visits all of them.
// A successful removal then shifts each entry after the removed one down by one
// place, with one RAM read and one write per entry, and ends the pass with a step
// that lowers the entry count. The next input transfer is taken once the result
// sits in the output register, while that result still waits. The store needs no
// clearing after reset; the entry count starts at zero.
module unique_id_set (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [uis_pkg::MODE_W-1:0]   mode,
  input  logic [uis_pkg::ID_W-1:0]     id_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [uis_pkg::STATUS_W-1:0] status,
  output logic [uis_pkg::COUNT_W-1:0]  entry_count
);
  import uis_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  uis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  uis_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .mode        (mode),
    .id_value    (id_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for unique_id_set: directed table, then biased random traffic.
module testbench;
  import uis_pkg::*;

  localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY_ALT = 2'd3;
  localparam int RANDOM_OPS  = 825;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    logic [MODE_W-1:0] op;
    logic [ID_W-1:0]   id;
    bit                typed;
    status_t           st;
    logic [COUNT_W-1:0] cnt;
  } op_row_t;

  typedef struct {
    status_t            st;
    logic [COUNT_W-1:0] cnt;
  } set_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [MODE_W-1:0]  mode = '0;
  logic [ID_W-1:0]    id_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] entry_count;

  logic [ID_W-1:0] model_ids[$];
  set_result_t     expected_results[$];
  op_row_t         dir_rows[$];
  logic [ID_W-1:0] id_pool[POOL_SIZE];

  bit steady = 1'b0;
  int ops_sent = 0;
  int results_checked = 0;
  int full_refusals = 0;
  int mismatches = 0;
  int hold_left = 0;
  int cycles = 0;

  unique_id_set i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .id_value(id_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .entry_count(entry_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic set_result_t predict_set_op(input logic [MODE_W-1:0] op,
                                                 input logic [ID_W-1:0] v);
    int pos;
    set_result_t r;
    pos = -1;
    for (int i = 0; i < model_ids.size(); i++) begin
      if (pos < 0 && model_ids[i] == v) pos = i;
    end
    if (op == MODE_INSERT) begin
      if (pos >= 0) begin
        r.st = STATUS_MISS;
      end else if (model_ids.size() >= CAPACITY) begin
        r.st = STATUS_FULL;
        full_refusals++;
      end else begin
        model_ids.push_back(v);
        r.st = STATUS_OK;
      end
    end else if (op == MODE_REMOVE) begin
      if (pos < 0) begin
        r.st = STATUS_MISS;
      end else begin
        model_ids.delete(pos);
        r.st = STATUS_OK;
      end
    end else begin
      r.st = (pos >= 0) ? STATUS_OK : STATUS_MISS;
    end
    r.cnt = COUNT_W'(model_ids.size());
    return r;
  endfunction

  task automatic add_row(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] v,
                         input bit typed, input status_t st, input logic [COUNT_W-1:0] cnt);
    op_row_t row;
    row.op = op;
    row.id = v;
    row.typed = typed;
    row.st = st;
    row.cnt = cnt;
    dir_rows.push_back(row);
  endtask

  task automatic offer(input logic [MODE_W-1:0] op, input logic [ID_W-1:0] v,
                       input bit typed, input status_t st, input logic [COUNT_W-1:0] cnt);
    set_result_t p;
    in_valid <= 1'b1;
    mode <= op;
    id_value <= v;
    do @(posedge clk); while (!in_ready);
    p = predict_set_op(op, v);
    if (typed) begin
      p.st = st;
      p.cnt = cnt;
    end
    expected_results.push_back(p);
    ops_sent++;
  endtask

  task automatic idle_gap();
    while (!steady && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      mode <= MODE_W'($urandom());
      id_value <= ID_W'($urandom());
      @(posedge clk);
    end
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin : result_check
    set_result_t p;
    bit took;
    took = !rst && out_valid && out_ready;
    if (took) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: status %0d, entry_count %0d",
                 $time, status, entry_count);
      end else begin
        p = expected_results.pop_front();
        if (status !== p.st) begin
          mismatches++;
          $display("%0t: status mismatch: expected %0d (%s), actual %0d",
                   $time, p.st, p.st.name(), status);
        end
        if (entry_count !== p.cnt) begin
          mismatches++;
          $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                   $time, p.cnt, entry_count);
        end
      end
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (took && (results_checked == 300 || results_checked == 650)) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("unique_id_set regression: fail");
      $finish;
    end
  end

  initial begin
    int k;
    int phase;
    int ins_pct;
    int r;
    logic [MODE_W-1:0] op;
    logic [ID_W-1:0] v;

    add_row(MODE_QUERY,  31'h0000_0000, 1'b1, STATUS_MISS, 5'd0);
    add_row(MODE_REMOVE, 31'h7FFF_FFFF, 1'b1, STATUS_MISS, 5'd0);
    add_row(MODE_INSERT, 31'h0000_0000, 1'b1, STATUS_OK,   5'd1);
    add_row(MODE_INSERT, 31'h7FFF_FFFF, 1'b1, STATUS_OK,   5'd2);
    add_row(MODE_INSERT, 31'h0000_0000, 1'b1, STATUS_MISS, 5'd2);
    add_row(MODE_QUERY_ALT, 31'h7FFF_FFFF, 1'b1, STATUS_OK, 5'd2);
    add_row(MODE_QUERY,  31'h5555_5555, 1'b1, STATUS_MISS, 5'd2);
    for (k = 1; k <= CAPACITY - 2; k++) begin
      add_row(MODE_INSERT, ID_W'(k * 32'h0913_5ACF), 1'b0, STATUS_OK, '0);
    end
    add_row(MODE_INSERT, 31'h2AAA_AAAA, 1'b1, STATUS_FULL, 5'd16);
    add_row(MODE_INSERT, 31'h0000_0000, 1'b1, STATUS_MISS, 5'd16);
    add_row(MODE_REMOVE, 31'h0000_0000, 1'b0, STATUS_OK, '0);
    add_row(MODE_REMOVE, ID_W'(7 * 32'h0913_5ACF), 1'b0, STATUS_OK, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      idle_gap();
      offer(dir_rows[i].op, dir_rows[i].id, dir_rows[i].typed, dir_rows[i].st,
            dir_rows[i].cnt);
    end

    for (k = 0; k < RANDOM_OPS; k++) begin
      phase = k / 100;
      if (k % 100 == 0) begin
        foreach (id_pool[i]) id_pool[i] = ID_W'($urandom());
      end
      case (phase % 4)
        0: ins_pct = 75;
        1: ins_pct = 30;
        2: ins_pct = 55;
        default: ins_pct = 20;
      endcase
      r = $urandom_range(99);
      if (r < ins_pct) begin
        op = MODE_INSERT;
      end else if (r < ins_pct + (100 - ins_pct) * 2 / 3) begin
        op = MODE_REMOVE;
      end else begin
        op = ($urandom_range(3) == 0) ? MODE_QUERY_ALT : MODE_QUERY;
      end
      r = $urandom_range(99);
      if (r < 45 && model_ids.size() > 0) begin
        v = model_ids[$urandom_range(model_ids.size() - 1)];
      end else if (r < 85) begin
        v = id_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        v = ID_W'($urandom());
      end
      steady <= (k >= 350 && k < 500);
      if (k == 600) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end else begin
        idle_gap();
      end
      offer(op, v, 1'b0, STATUS_OK, '0);
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Sent %0d set operations (%0d inserts refused on a full set); checked %0d results.",
             ops_sent, full_refusals, results_checked);
    $display("Mismatches found: %0d", mismatches);
    if (mismatches == 0) begin
      $display("unique_id_set regression: pass");
    end else begin
      $display("unique_id_set regression: fail");
    end
    $finish;
  end

endmodule
